>>> hdl/fwrid_pkg.sv
// Shared types and constants for the keyed-removal FIFO.
// Holds the operation codes, the controller states and the fixed port widths.
// No dependencies.
package fwrid_pkg;

    // Fixed widths of the stream payload fields
    localparam int KIND_W   = 2;
    localparam int ITEM_W   = 8;
    localparam int OUT_ID_W = 8;
    localparam int COUNT_W  = 5;
    localparam int M_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

>>> hdl/fwrid_mem.sv
// Slot storage for the keyed-removal FIFO.
// Simple dual-port memory: one write port, one read port with registered data.
// No dependencies.
module fwrid_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/fifo_with_remove_by_id_top.sv
// Top level of the identifier FIFO with removal by identifier.
// Depends on fwrid_pkg and fwrid_mem.
//
//   channel | signals                          | payload
//   --------+----------------------------------+------------------------------------------
//   s_*     | s_tvalid s_tready s_tdata s_tuser | request: tuser = kind, tdata = item_id
//   m_*     | m_tvalid m_tready m_tdata         | result: out_id ok overflow entry_count empty
//
// One request at a time. Enqueue goes straight to its result; dequeue and peek
// first make one memory read of the head, but not on an empty queue. Remove scans
// with the single read port of the slot memory, one entry a cycle; on a match it
// then moves later entries one place toward the head, one a cycle.
// Reset empties the queue at once; the slot memory is not cleared. A result waits
// in the output register while the next request is taken; a request finishes only
// once that register is free.
module fifo_with_remove_by_id_top
    import fwrid_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ITEM_W-1:0]   s_tdata,   // [7:0] item_id
    input  logic [KIND_W-1:0]   s_tuser,   // [1:0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [7:0] out_id, [8] ok, [9] overflow,
                                           // [14:10] entry_count, [15] empty_res
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    // head + offset wrapped onto the ring; the sum stays below twice the depth
    function automatic logic [PW-1:0] ring_idx(input logic [PW-1:0] head,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         issue_pos_reg, issue_pos_next;
    logic [CW-1:0]         wr_pos_reg, wr_pos_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [OUT_ID_W-1:0]   res_id_reg, res_id_next;
    logic                  res_ok_reg, res_ok_next;
    logic                  res_ovf_reg, res_ovf_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                  mem_wr_en;
    logic [PW-1:0]         mem_wr_addr;
    logic [ID_WIDTH-1:0]   mem_wr_data;
    logic                  mem_rd_en;
    logic [PW-1:0]         mem_rd_addr;
    logic [ID_WIDTH-1:0]   mem_rd_data;

    logic                  s_fire;
    logic                  is_full;
    logic                  is_empty;
    logic                  hit;
    logic                  out_free;
    logic                  more_to_read;
    op_t                   in_op;

    fwrid_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_fire       = s_tvalid && s_tready;
    assign in_op        = op_t'(s_tuser);
    assign is_full      = (count_reg == CW'(QUEUE_DEPTH));
    assign is_empty     = (count_reg == '0);
    assign hit          = rd_valid_reg && (mem_rd_data == id_reg);
    assign out_free     = !out_valid_reg || m_tready;
    assign more_to_read = (issue_pos_reg < count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (in_op)
                        OP_ENQ:          state_next = ST_DONE;
                        OP_DEQ, OP_PEEK: state_next = is_empty ? ST_DONE : ST_HEAD;
                        OP_REMOVE:       state_next = ST_SEARCH;
                        default:         state_next = ST_DONE;
                    endcase
                end
            end
            ST_HEAD:
            begin
                state_next = ST_DONE;
            end
            ST_SEARCH:
            begin
                priority if (hit)
                begin
                    state_next = ST_SHIFT;
                end
                else if (!more_to_read)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (!rd_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result
    always_comb
    begin
        op_next        = op_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        issue_pos_next = issue_pos_reg;
        wr_pos_next    = wr_pos_reg;
        rd_valid_next  = 1'b0;
        res_id_next    = res_id_reg;
        res_ok_next    = res_ok_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = ring_idx(head_reg, count_reg);
        mem_wr_data    = id_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next        = in_op;
                    id_next        = ID_WIDTH'(s_tdata);
                    res_id_next    = '0;
                    res_ok_next    = 1'b0;
                    res_ovf_next   = 1'b0;
                    issue_pos_next = '0;
                    unique case (in_op)
                        OP_ENQ:
                        begin
                            if (is_full)
                            begin
                                res_ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = ID_WIDTH'(s_tdata);
                                count_next  = count_reg + 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            res_ok_next = !is_empty;
                            mem_rd_en   = !is_empty;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_HEAD:
            begin
                res_id_next = OUT_ID_W'(mem_rd_data);
                if (op_reg == OP_DEQ)
                begin
                    head_next  = ring_idx(head_reg, CW'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            ST_SEARCH:
            begin
                // read one entry a cycle; the compare sees last cycle's read
                mem_rd_en   = more_to_read;
                mem_rd_addr = ring_idx(head_reg, issue_pos_reg);
                rd_valid_next = more_to_read;
                if (more_to_read)
                begin
                    issue_pos_next = issue_pos_reg + 1'b1;
                end
                if (hit)
                begin
                    wr_pos_next = issue_pos_reg - 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (rd_valid_reg)
                begin
                    // move the entry just read one place toward the head
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = ring_idx(head_reg, wr_pos_reg);
                    mem_wr_data = mem_rd_data;
                    wr_pos_next = wr_pos_reg + 1'b1;
                    mem_rd_en   = more_to_read;
                    mem_rd_addr = ring_idx(head_reg, issue_pos_reg);
                    rd_valid_next = more_to_read;
                    if (more_to_read)
                    begin
                        issue_pos_next = issue_pos_reg + 1'b1;
                    end
                end
                else
                begin
                    count_next  = count_reg - 1'b1;
                    res_ok_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {is_empty, COUNT_W'(count_reg), res_ovf_reg,
                                      res_ok_reg, res_id_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        issue_pos_reg <= issue_pos_next;
        wr_pos_reg    <= wr_pos_next;
        res_id_reg    <= res_id_next;
        res_ok_reg    <= res_ok_next;
        res_ovf_reg   <= res_ovf_next;
        out_data_reg  <= out_data_next;
    end

endmodule

>>> tb/sv/fwrid_tb_pkg.sv
// Scoreboard for the keyed-removal FIFO testbench.
// Keeps its own copy of the queued identifiers and the expected results.
// Depends on fwrid_pkg.
package fwrid_tb_pkg;
    import fwrid_pkg::*;

    localparam int TB_DEPTH = 16;

    // Same layout as m_tdata, lowest field last
    typedef struct packed {
        logic                empty_res;
        logic [COUNT_W-1:0]  entry_count;
        logic                overflow;
        logic                ok;
        logic [OUT_ID_W-1:0] out_id;
    } queue_result_t;

    class ready_queue_scoreboard;
        logic [ITEM_W-1:0] queued_ids[$];
        queue_result_t     expected_results[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted request to the shadow queue and record its result
        function void note_request(op_t kind, logic [ITEM_W-1:0] item_id);
            queue_result_t r;
            int            hit;
            r   = '0;
            hit = -1;
            case (kind)
                OP_ENQ:
                begin
                    if (queued_ids.size() >= TB_DEPTH)
                    begin
                        r.overflow = 1'b1;
                    end
                    else
                    begin
                        queued_ids.push_back(item_id);
                        r.ok = 1'b1;
                    end
                end
                OP_DEQ, OP_PEEK:
                begin
                    if (queued_ids.size() > 0)
                    begin
                        r.out_id = queued_ids[0];
                        r.ok     = 1'b1;
                        if (kind == OP_DEQ)
                        begin
                            void'(queued_ids.pop_front());
                        end
                    end
                end
                default:
                begin
                    // drop the oldest match, later entries close up
                    for (int i = 0; i < queued_ids.size(); i++)
                    begin
                        if (hit < 0 && queued_ids[i] == item_id)
                        begin
                            hit = i;
                        end
                    end
                    if (hit >= 0)
                    begin
                        queued_ids.delete(hit);
                        r.ok = 1'b1;
                    end
                end
            endcase
            r.entry_count = COUNT_W'(queued_ids.size());
            r.empty_res   = (queued_ids.size() == 0);
            expected_results.push_back(r);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.out_id !== want.out_id)
            begin
                $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
                errors++;
            end
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0b, got %0b", want.ok, got.ok);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.empty_res !== want.empty_res)
            begin
                $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/fifo_with_remove_by_id_top_tb.sv
// Regression bench for fifo_with_remove_by_id_top: directed corner requests, then
// random request mixes with random stalls on both streams, checked by the scoreboard.
// Depends on fwrid_pkg and fwrid_tb_pkg.
module fifo_with_remove_by_id_top_tb;
    import fwrid_pkg::*;
    import fwrid_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_TAIL  = 40;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ITEM_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    ready_queue_scoreboard sb = new();

    int  tx_idle_max = 12;
    int  rx_idle_max = 12;
    bit  hold_output = 1'b0;
    int  cycles      = 0;

    logic [ITEM_W-1:0] fill_ids [TB_DEPTH] = '{
        8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h5A, 8'h7F,
        8'hFE, 8'h3C, 8'hC3, 8'h10, 8'h08, 8'h04, 8'h02, 8'h40
    };

    fifo_with_remove_by_id_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("fifo_with_remove_by_id_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
    end

    // Result side: stall a random number of cycles per result, or hold for a
    // long stretch when asked
    initial
    begin
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_output)
            begin
                stall       = LONG_HOLD;
                hold_output = 1'b0;
            end
            else
            begin
                stall = $urandom_range(0, rx_idle_max);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one request after a random gap; record it once it is taken
    task automatic send_request(input op_t kind, input logic [ITEM_W-1:0] item_id);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= item_id;
        do @(posedge clk); while (!s_tready);
        sb.note_request(kind, item_id);
    endtask

    // Drop the last request so it is not taken twice, then wait for all results
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Random request mix; remove mostly targets an identifier that is queued
    task automatic run_random(input int count, input int enq_pct, input int rem_pct);
        int                roll;
        op_t               kind;
        logic [ITEM_W-1:0] item_id;
        for (int n = 0; n < count; n++)
        begin
            roll    = $urandom_range(0, 99);
            item_id = ITEM_W'($urandom_range(0, 255));
            if (roll < enq_pct)
            begin
                kind = OP_ENQ;
                // a small pool makes duplicate identifiers common
                if ($urandom_range(0, 3) == 0)
                begin
                    item_id = ITEM_W'($urandom_range(0, 7));
                end
            end
            else if (roll < enq_pct + rem_pct)
            begin
                kind = OP_REMOVE;
                if (sb.queued_ids.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    item_id = sb.queued_ids[$urandom_range(0, sb.queued_ids.size() - 1)];
                end
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                kind = OP_DEQ;
            end
            else
            begin
                kind = OP_PEEK;
            end
            send_request(kind, item_id);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: nothing to take or remove
        send_request(OP_DEQ, 8'h00);
        send_request(OP_PEEK, 8'hFF);
        send_request(OP_REMOVE, 8'h00);
        foreach (fill_ids[i])
        begin
            send_request(OP_ENQ, fill_ids[i]);
        end
        // full queue refuses the enqueue
        send_request(OP_ENQ, 8'h99);
        send_request(OP_PEEK, 8'h3C);
        // middle entry, oldest of two duplicates
        send_request(OP_REMOVE, 8'h5A);
        send_request(OP_REMOVE, 8'h99);
        send_request(OP_DEQ, 8'hAA);
        send_request(OP_REMOVE, 8'h40);

        run_random(120, 55, 20);

        tx_idle_max = 0;
        rx_idle_max = 0;
        run_random(100, 35, 30);

        // back up the output while requests keep coming
        wait_for_drain();
        hold_output = 1'b1;
        run_random(40, 50, 25);

        tx_idle_max = 12;
        rx_idle_max = 12;
        run_random(150, 30, 30);

        wait_for_drain();
        tx_idle_max = 3;
        run_random(140, 50, 25);

        wait_for_drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("fifo_with_remove_by_id_top regression: pass");
        end
        else
        begin
            $display("fifo_with_remove_by_id_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/fwrid_pkg.sv
hdl/fwrid_mem.sv
hdl/fifo_with_remove_by_id_top.sv
tb/sv/fwrid_tb_pkg.sv
tb/sv/fifo_with_remove_by_id_top_tb.sv
